FILE: rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the stack region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int OFS_W        = 21;
  localparam int SUM_W        = OFS_W + 2;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_CHUNKS   = 256;
  localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W        = $clog2(MAX_CHUNKS);

  localparam logic [OFS_W-1:0] REGION_RESET = OFS_W'(65536);

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_NOT_TOP = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the item offered on the input channel
    logic commit;   // apply the item and load the result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sra_ctrl.sv
// ----------------------------------------------------------------------------
// sra_ctrl
// Controller: sequences capture and commit and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sra_pkg::cmd_t      cmd
);

  sra_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      sra_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = sra_pkg::S_EXEC;
        end
      end
      sra_pkg::S_EXEC: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = sra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sra_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.commit | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/sra_dp.sv
// ----------------------------------------------------------------------------
// sra_dp
// Datapath: allocator state, chunk size memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sra_pkg::cmd_t               cmd,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sra_pkg::OFS_W-1:0]   cfg_wr_data,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [sra_pkg::OFS_W-1:0]   in_request_bytes,
  input  wire logic [sra_pkg::OFS_W-1:0]   in_release_offset,
  output logic      [sra_pkg::OFS_W-1:0]   out_data_offset,
  output logic      [1:0]                  out_status,
  output logic      [sra_pkg::OFS_W-1:0]   out_bytes_in_use
);

  localparam logic [sra_pkg::SUM_W-1:0] ALIGN_M1 = sra_pkg::SUM_W'(sra_pkg::ALIGN_BYTES - 1);
  localparam logic [sra_pkg::SUM_W-1:0] HDR_S    = sra_pkg::SUM_W'(sra_pkg::HEADER_BYTES);
  localparam logic [sra_pkg::OFS_W-1:0] HDR_O    = sra_pkg::OFS_W'(sra_pkg::HEADER_BYTES);
  localparam logic [sra_pkg::CNT_W-1:0] CNT_MAX  = sra_pkg::CNT_W'(sra_pkg::MAX_CHUNKS);
  localparam logic [sra_pkg::CNT_W-1:0] CNT_ONE  = sra_pkg::CNT_W'(1);
  localparam logic [sra_pkg::CNT_W-1:0] CNT_TWO  = sra_pkg::CNT_W'(2);

  // Item registers.
  sra_pkg::op_t                 op_r;
  logic [sra_pkg::OFS_W-1:0]    req_r;
  logic [sra_pkg::OFS_W-1:0]    rel_r;

  // Allocator state.
  logic [sra_pkg::OFS_W-1:0]    region_r;
  logic [sra_pkg::OFS_W-1:0]    used_r, used_nxt;
  logic [sra_pkg::OFS_W-1:0]    top_r, top_nxt;
  logic [sra_pkg::CNT_W-1:0]    count_r, count_nxt;

  // Chunk size memory and its registered read port.
  logic [sra_pkg::OFS_W-1:0]    size_mem [sra_pkg::MAX_CHUNKS];
  logic [sra_pkg::OFS_W-1:0]    below_r;
  logic [sra_pkg::CNT_W-1:0]    rd_addr_full;
  logic                         mem_we;

  // Result register.
  logic [sra_pkg::OFS_W-1:0]    data_r, data_nxt;
  sra_pkg::status_t             status_r, status_nxt;
  logic [sra_pkg::OFS_W-1:0]    inuse_r;

  logic [sra_pkg::SUM_W-1:0]    aligned_sz;
  logic [sra_pkg::SUM_W-1:0]    need;
  logic [sra_pkg::SUM_W-1:0]    cap;
  logic [sra_pkg::SUM_W-1:0]    top_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= sra_pkg::REGION_RESET;
      used_r   <= '0;
      top_r    <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        region_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        used_r  <= used_nxt;
        top_r   <= top_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= sra_pkg::op_t'(in_operation);
      req_r <= in_request_bytes;
      rel_r <= in_release_offset;
    end
    if (cmd.commit) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      inuse_r  <= used_nxt;
    end
  end

  // The size of the chunk below the top one is read every cycle, so it is
  // ready when a free item is applied.
  assign rd_addr_full = count_r - CNT_TWO;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[count_r[sra_pkg::IDX_W-1:0]] <= aligned_sz[sra_pkg::OFS_W-1:0];
    end
    below_r <= size_mem[rd_addr_full[sra_pkg::IDX_W-1:0]];
  end

  assign aligned_sz = ({2'b00, req_r} + ALIGN_M1) & ~ALIGN_M1;
  assign need       = {2'b00, used_r} + aligned_sz + HDR_S;
  assign cap        = {2'b00, region_r} & ~ALIGN_M1;
  assign top_data   = {2'b00, top_r} + HDR_S;

  always_comb begin
    used_nxt   = used_r;
    top_nxt    = top_r;
    count_nxt  = count_r;
    data_nxt   = '0;
    status_nxt = sra_pkg::ST_OK;
    mem_we     = 1'b0;
    case (op_r)
      sra_pkg::OP_ALLOC: begin
        if (need > cap || count_r >= CNT_MAX) begin
          status_nxt = sra_pkg::ST_NO_ROOM;
        end else begin
          mem_we    = cmd.commit;
          top_nxt   = used_r;
          count_nxt = count_r + CNT_ONE;
          used_nxt  = need[sra_pkg::OFS_W-1:0];
          data_nxt  = used_r + HDR_O;
        end
      end
      sra_pkg::OP_FREE: begin
        if (count_r == '0) begin
          status_nxt = sra_pkg::ST_EMPTY;
        end else if ({2'b00, rel_r} != top_data) begin
          status_nxt = sra_pkg::ST_NOT_TOP;
        end else begin
          count_nxt = count_r - CNT_ONE;
          used_nxt  = top_r;
          if (count_r > CNT_ONE) begin
            top_nxt = top_r - below_r - HDR_O;
          end else begin
            top_nxt = '0;
          end
        end
      end
      sra_pkg::OP_FREE_ALL: begin
        used_nxt  = '0;
        top_nxt   = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_data_offset  = data_r;
  assign out_status       = status_r;
  assign out_bytes_in_use = inuse_r;

endmodule

`default_nettype wire

FILE: rtl/stack_region_allocator.sv
// ----------------------------------------------------------------------------
// stack_region_allocator
// Last-in-first-out allocator over a byte region with per-chunk headers.
// ----------------------------------------------------------------------------
// Sequence: the item is captured at its input transfer and applied once the
// result register is empty or drains, which loads that register; the result
// transfer can follow once the result register holds it.
// The input stalls while an item waits to be applied, so a new item is taken
// only after the current one has been applied.
// Reset: synchronous, active low; usage, top header and chunk count clear,
// region size returns to 65536 bytes, the size memory is not cleared.
`default_nettype none

module stack_region_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration: region size in bytes.
  input  wire logic                        cfg_wr_en,
  input  wire logic [sra_pkg::OFS_W-1:0]   cfg_wr_data,
  // Input channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [sra_pkg::OFS_W-1:0]   in_request_bytes,
  input  wire logic [sra_pkg::OFS_W-1:0]   in_release_offset,
  // Result channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [sra_pkg::OFS_W-1:0]   out_data_offset,
  output logic      [1:0]                  out_status,
  output logic      [sra_pkg::OFS_W-1:0]   out_bytes_in_use
);

  // The controller takes an input transfer in its idle state and applies the
  // item once the result register can take it. The result sits in an output
  // register, so a new item can be taken while the previous result waits
  // for its transfer; only the commit waits for that register to drain.
  sra_pkg::cmd_t cmd;

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds usage, the top chunk's header offset, the chunk count
  // and a memory of aligned chunk sizes. A pop needs the size of the chunk
  // beneath the top one; that entry is read ahead every cycle so that it is
  // ready by the time the free item is applied.
  sra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_operation      (in_operation),
    .in_request_bytes  (in_request_bytes),
    .in_release_offset (in_release_offset),
    .out_data_offset   (out_data_offset),
    .out_status        (out_status),
    .out_bytes_in_use  (out_bytes_in_use)
  );

endmodule

`default_nettype wire
